>>> design/pcm_pkg.sv
package pcm_pkg;

    localparam int MAX_GENES_DEF   = 8;
    localparam int MAX_SAMPLES_DEF = 256;
    localparam logic signed [15:0] CORR_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        OP_LOAD_STATS = 2'd0,
        OP_LOAD_EXPR  = 2'd1,
        OP_COMPUTE    = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ACC,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         gene_slot;
        logic [7:0]         sample_index;
        logic signed [15:0] expression_value;
        logic signed [15:0] gene_mean;
        logic [31:0]        gene_variance;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         column;
        logic signed [15:0] correlation;
        logic [4:0]         pairs_compared;
        logic               last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic start_entry;   // latch stats, clear accumulator
        logic acc_step;      // one sample product
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } dp_stat_t;

endpackage

>>> design/pcm_datapath.sv
module pcm_datapath #(
    parameter int MAX_GENES   = 8,
    parameter int MAX_SAMPLES = 256,
    parameter int GW = $clog2(MAX_GENES),
    parameter int SW = $clog2(MAX_SAMPLES) > 0 ? $clog2(MAX_SAMPLES) : 1,
    parameter int NW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcm_pkg::in_item_t     load_item,
    input  logic                  load_en,
    input  logic [GW-1:0]         row_idx,
    input  logic [GW-1:0]         col_idx,
    input  logic [SW-1:0]         samp_idx,
    input  logic                  rd_en,
    input  logic [NW-1:0]         n_eff,
    input  pcm_pkg::dp_cmd_t      cmd,
    output pcm_pkg::dp_stat_t     stat,
    output logic signed [15:0]    corr
);
    import pcm_pkg::*;

    localparam int DEPTH = MAX_GENES * MAX_SAMPLES;
    localparam int AW    = GW + SW;
    localparam int ACCW  = 34 + SW + 2;
    localparam int MAGW  = ACCW + 14;
    localparam int DENW  = 32 + NW;
    localparam int QW    = 15;

    logic [15:0] expr_mem_a [DEPTH];
    logic [15:0] expr_mem_b [DEPTH];
    logic [15:0] mean_mem   [MAX_GENES];
    logic [31:0] var_mem    [MAX_GENES];

    logic [15:0] rd_a_reg, rd_b_reg;
    logic        rd_v_reg;
    logic signed [15:0] mean_a_reg, mean_b_reg;
    logic [31:0] var_a_reg, var_b_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [16:0] da, db;
    logic signed [33:0] prod;

    // two copies of the expression store give two read ports
    always_ff @(posedge clk)
    begin
        if (load_en && load_item.operation == OP_LOAD_EXPR
            && 32'(load_item.gene_slot) < MAX_GENES
            && 32'(load_item.sample_index) < MAX_SAMPLES)
        begin
            expr_mem_a[AW'(load_item.gene_slot) * AW'(MAX_SAMPLES)
                       + AW'(load_item.sample_index)] <= load_item.expression_value;
            expr_mem_b[AW'(load_item.gene_slot) * AW'(MAX_SAMPLES)
                       + AW'(load_item.sample_index)] <= load_item.expression_value;
        end
        if (load_en && load_item.operation == OP_LOAD_STATS
            && 32'(load_item.gene_slot) < MAX_GENES)
        begin
            mean_mem[GW'(load_item.gene_slot)] <= load_item.gene_mean;
            var_mem[GW'(load_item.gene_slot)]  <= load_item.gene_variance;
        end
        rd_a_reg <= expr_mem_a[AW'(row_idx) * AW'(MAX_SAMPLES) + AW'(samp_idx)];
        rd_b_reg <= expr_mem_b[AW'(col_idx) * AW'(MAX_SAMPLES) + AW'(samp_idx)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_entry)
        begin
            mean_a_reg <= mean_mem[row_idx];
            mean_b_reg <= mean_mem[col_idx];
            var_a_reg  <= var_mem[row_idx];
            var_b_reg  <= var_mem[col_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_v_reg <= 1'b0;
        else
            rd_v_reg <= rd_en;
    end

    assign da   = 17'(signed'(rd_a_reg)) - 17'(mean_a_reg);
    assign db   = 17'(signed'(rd_b_reg)) - 17'(mean_b_reg);
    assign prod = 34'(da) * 34'(db);

    always_ff @(posedge clk)
    begin
        if (cmd.start_entry)
            acc_reg <= '0;
        else if (rd_v_reg)
            acc_reg <= acc_reg + ACCW'(prod);
    end

    // variance product, two 32x16 partial products
    logic [63:0] vprod_reg;
    logic [1:0]  vp_cnt_reg;
    // integer square root, two bits per step
    logic [63:0] sq_rem_reg;
    logic [31:0] sq_root_reg;
    logic [5:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [33:0] trial;
    logic [65:0] rem_sh;

    assign rem_sh = {sq_rem_reg, vprod_reg[63:62]} ;
    assign trial  = {sq_root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
            vp_cnt_reg  <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
            vp_cnt_reg  <= 2'd2;
            sq_cnt_reg  <= 6'd32;
        end
        else if (cmd.sqrt_step && sq_busy_reg)
        begin
            if (vp_cnt_reg != 2'd0)
                vp_cnt_reg <= vp_cnt_reg - 2'd1;
            else if (sq_cnt_reg != 6'd0)
                sq_cnt_reg <= sq_cnt_reg - 6'd1;
            else
                sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            vprod_reg   <= '0;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step && sq_busy_reg)
        begin
            if (vp_cnt_reg == 2'd2)
                vprod_reg <= {16'd0, 48'(var_a_reg) * 48'(var_b_reg[15:0])};
            else if (vp_cnt_reg == 2'd1)
                vprod_reg <= vprod_reg + {48'(var_a_reg) * 48'(var_b_reg[31:16]), 16'd0};
            else if (sq_cnt_reg != 6'd0)
            begin
                vprod_reg <= {vprod_reg[61:0], 2'b00};
                if (rem_sh[63:0] >= 64'(trial) && rem_sh[65:64] == 2'b00)
                begin
                    sq_rem_reg  <= rem_sh[63:0] - 64'(trial);
                    sq_root_reg <= {sq_root_reg[30:0], 1'b1};
                end
                else if (rem_sh[65:64] != 2'b00)
                begin
                    sq_rem_reg  <= 64'(rem_sh - 66'(trial));
                    sq_root_reg <= {sq_root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= rem_sh[63:0];
                    sq_root_reg <= {sq_root_reg[30:0], 1'b0};
                end
            end
        end
    end
    assign stat.sqrt_done = !sq_busy_reg;

    // q = floor((2*mag*2^14 + den) / (2*den)), restoring division, one bit a step
    logic [DENW:0]   den2_reg;
    logic [MAGW+1:0] num_reg;
    logic [DENW+1:0] drem_reg;
    logic [QW-1:0]   q_reg;
    logic [7:0]      dv_cnt_reg;
    logic            dv_busy_reg;
    logic            neg_reg;
    logic            zero_reg;
    logic [DENW+1:0] drem_sh;
    logic [ACCW-1:0] mag_abs;

    assign mag_abs = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);
    assign drem_sh = {drem_reg[DENW:0], num_reg[MAGW+1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 8'(MAGW + 3);
        end
        else if (cmd.div_step && dv_busy_reg)
        begin
            if (dv_cnt_reg != 8'd0)
                dv_cnt_reg <= dv_cnt_reg - 8'd1;
            else
                dv_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den2_reg <= {DENW'(n_eff) * DENW'(sq_root_reg), 1'b0};
            zero_reg <= (n_eff == '0) || (sq_root_reg == '0);
            neg_reg  <= acc_reg[ACCW-1];
            num_reg  <= '0;
            drem_reg <= '0;
            q_reg    <= '0;
        end
        else if (cmd.div_step && dv_busy_reg && dv_cnt_reg == 8'(MAGW + 3))
        begin
            // den stable now; form numerator 2*mag*2^14 + den
            num_reg <= {1'b0, mag_abs, 14'd0, 1'b0} + (MAGW+2)'(den2_reg[DENW:1]);
        end
        else if (cmd.div_step && dv_busy_reg && dv_cnt_reg != 8'd0)
        begin
            num_reg <= {num_reg[MAGW:0], 1'b0};
            if (drem_sh >= (DENW+2)'(den2_reg))
            begin
                drem_reg <= drem_sh - (DENW+2)'(den2_reg);
                q_reg    <= (q_reg[QW-1] || q_reg == QW'(16384)) ? QW'(16384)
                            : (QW'({q_reg, 1'b1}) > QW'(16384) || q_reg[QW-1:QW-1] != 1'b0
                               ? QW'(16384) : QW'({q_reg, 1'b1}));
            end
            else
            begin
                drem_reg <= drem_sh;
                q_reg    <= (q_reg > QW'(8192)) ? QW'(16384) : QW'({q_reg, 1'b0});
            end
        end
    end
    assign stat.div_done = !dv_busy_reg;

    always_comb
    begin
        if (zero_reg)
            corr = '0;
        else if (neg_reg)
            corr = -16'(signed'({1'b0, q_reg}));
        else
            corr = 16'(q_reg);
    end
endmodule

>>> design/pcm_ctrl.sv
module pcm_ctrl #(
    parameter int MAX_GENES   = 8,
    parameter int MAX_SAMPLES = 256,
    parameter int GW = $clog2(MAX_GENES),
    parameter int SW = $clog2(MAX_SAMPLES) > 0 ? $clog2(MAX_SAMPLES) : 1,
    parameter int NW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 compute_go,
    input  logic [3:0]           gene_count,
    input  logic [8:0]           sample_count,
    output logic                 busy,
    output logic [GW-1:0]        row_idx,
    output logic [GW-1:0]        col_idx,
    output logic [SW-1:0]        samp_idx,
    output logic                 rd_en,
    output logic [NW-1:0]        n_eff,
    output pcm_pkg::dp_cmd_t     cmd,
    input  pcm_pkg::dp_stat_t    stat,
    input  logic signed [15:0]   corr,
    output pcm_pkg::out_item_t   out_item,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import pcm_pkg::*;

    state_t state_reg, state_next;
    logic [GW-1:0] r_reg, r_next, c_reg, c_next, klast_reg, klast_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] s_reg, s_next;
    logic [4:0]    pairs_reg, pairs_next;
    logic          wait_reg, wait_next;
    out_item_t     ob_reg, ob_next;
    logic          ov_reg, ov_next;
    logic [GW:0]   k_clamp;
    logic [NW:0]   n_clamp;
    logic          diag, is_last;

    always_comb
    begin
        if (gene_count == 4'd0)
            k_clamp = (GW+1)'(1);
        else if (32'(gene_count) > MAX_GENES)
            k_clamp = (GW+1)'(MAX_GENES);
        else
            k_clamp = (GW+1)'(gene_count);
        if (32'(sample_count) > MAX_SAMPLES)
            n_clamp = (NW+1)'(MAX_SAMPLES);
        else
            n_clamp = (NW+1)'(sample_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            klast_reg <= '0;
            n_reg     <= '0;
            s_reg     <= '0;
            pairs_reg <= '0;
            wait_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            klast_reg <= klast_next;
            n_reg     <= n_next;
            s_reg     <= s_next;
            pairs_reg <= pairs_next;
            wait_reg  <= wait_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
    end

    assign diag    = (r_reg == c_reg);
    assign is_last = (r_reg == klast_reg) && (c_reg == klast_reg);
    assign row_idx = (r_reg < c_reg) ? r_reg : c_reg;
    assign col_idx = (r_reg < c_reg) ? c_reg : r_reg;
    assign samp_idx = SW'(s_reg);
    assign n_eff   = n_reg;
    assign busy    = (state_reg != ST_IDLE) || ov_reg;
    assign out_item  = ob_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        klast_next = klast_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        pairs_next = pairs_reg;
        wait_next  = 1'b0;
        ob_next    = ob_reg;
        ov_next    = ov_reg;
        rd_en      = 1'b0;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (compute_go)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    klast_next = GW'(k_clamp - 1'b1);
                    n_next     = NW'(n_clamp);
                    pairs_next = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start_entry = 1'b1;
                s_next = '0;
                if (diag)
                    state_next = ST_EMIT;
                else
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (s_reg < n_reg)
                begin
                    rd_en  = 1'b1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    // drain the read register and the accumulator before the square root
                    wait_next = 1'b1;
                    if (wait_reg)
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ob_next.row    = 3'(r_reg);
                    ob_next.column = 3'(c_reg);
                    ob_next.correlation = diag ? CORR_ONE : corr;
                    ob_next.pairs_compared = (c_reg > r_reg) ? pairs_reg + 5'd1 : pairs_reg;
                    ob_next.last   = is_last;
                    ov_next        = 1'b1;
                    pairs_next     = ob_next.pairs_compared;
                    if (is_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        if (c_reg == klast_reg)
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                            c_next = c_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

>>> design/pearson_correlation_matrix_core.sv
// pearson correlation matrix core
// in channel (in_valid/in_ready/in_item): load stats, load expression or compute
// out channel (out_valid/out_ready/out_item): one item per matrix entry, row-major,
// last set on the final entry of a compute
// apb port: gene_count at 0x0, sample_count at 0x4
// load items are taken one per cycle while the core is not busy and give no result
// a compute item blocks the input until its last entry has left the output register
// each off-diagonal entry runs the centred product sum
// (one sample per cycle from a two-port expression store), then the
// variance product and the 2-bit-a-step square root, then the
// bit-serial rounding divide and an emit step;
// diagonal entries skip these and go straight to the emit step
// a stalled receiver holds the output register and the sequencer waits
// reset clears the control state and the registers to gene_count 8,
// sample_count 0; the stores are undefined until loaded, no clearing pass
module pearson_correlation_matrix_core #(
    parameter int MAX_GENES   = pcm_pkg::MAX_GENES_DEF,
    parameter int MAX_SAMPLES = pcm_pkg::MAX_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcm_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output pcm_pkg::out_item_t out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pcm_pkg::*;

    localparam int GW = $clog2(MAX_GENES);
    localparam int SW = $clog2(MAX_SAMPLES) > 0 ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam logic [2:0] ADDR_GENES   = 3'h0;
    localparam logic [2:0] ADDR_SAMPLES = 3'h4;

    logic [3:0] gene_count_reg;
    logic [8:0] sample_count_reg;
    logic       busy, accept, compute_go, rd_en;
    logic [GW-1:0] row_idx, col_idx;
    logic [SW-1:0] samp_idx;
    logic [NW-1:0] n_eff;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic signed [15:0] corr;

    // config registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gene_count_reg   <= 4'd8;
            sample_count_reg <= 9'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_GENES:   gene_count_reg   <= pwdata[3:0];
                ADDR_SAMPLES: sample_count_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_GENES:   prdata = {28'd0, gene_count_reg};
            ADDR_SAMPLES: prdata = {23'd0, sample_count_reg};
            default:      prdata = '0;
        endcase
    end

    // input handshake: loads go straight to the stores
    assign in_ready   = !busy;
    assign accept     = in_valid && in_ready;
    assign compute_go = accept && in_item.operation == OP_COMPUTE;

    pcm_ctrl #(
        .MAX_GENES(MAX_GENES), .MAX_SAMPLES(MAX_SAMPLES),
        .GW(GW), .SW(SW), .NW(NW)
    ) u_ctrl (
        .clk, .rst_n, .compute_go,
        .gene_count(gene_count_reg), .sample_count(sample_count_reg),
        .busy, .row_idx, .col_idx, .samp_idx, .rd_en, .n_eff,
        .cmd, .stat, .corr, .out_item, .out_valid, .out_ready
    );

    pcm_datapath #(
        .MAX_GENES(MAX_GENES), .MAX_SAMPLES(MAX_SAMPLES),
        .GW(GW), .SW(SW), .NW(NW)
    ) u_dp (
        .clk, .rst_n, .load_item(in_item), .load_en(accept),
        .row_idx, .col_idx, .samp_idx, .rd_en, .n_eff,
        .cmd, .stat, .corr
    );
endmodule

>>> design/pcm_checker.sv
module pcm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input pcm_pkg::out_item_t out_item
);
    import pcm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    a_diag_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.row == out_item.column |-> out_item.correlation == CORR_ONE)
        else $error("diagonal entry not one");

    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.correlation <= CORR_ONE && out_item.correlation >= -CORR_ONE)
        else $error("correlation out of range");

    a_no_input_mid_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> !in_ready)
        else $error("input taken during a matrix");
endmodule

bind pearson_correlation_matrix_core pcm_checker u_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_item
);
